### rtl/core/kmr_pkg.sv
// shared types, request and event codes, and defaults for the key macro recorder
package kmr_pkg;

    // default geometry
    localparam int SLOTS_DEF   = 5;
    localparam int RECORDS_DEF = 32;

    // payload widths
    localparam int REQ_W   = 3;
    localparam int EV_W    = 3;
    localparam int CODE_W  = 8;
    localparam int SEL_W   = 3;
    localparam int ACT_W   = 4;
    localparam int WAIT_W  = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RECORD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MARK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_PLAY   = 3'd6;

    // event kinds
    localparam logic [EV_W-1:0] EV_ADD_KEY = 3'd0;
    localparam logic [EV_W-1:0] EV_DEL_KEY = 3'd1;
    localparam logic [EV_W-1:0] EV_ADD_MOD = 3'd2;
    localparam logic [EV_W-1:0] EV_DEL_MOD = 3'd3;
    localparam logic [EV_W-1:0] EV_TYPE    = 3'd4;

    // action code of the closing clear
    localparam logic [ACT_W-1:0] ACT_FINAL = 4'd8;

    // one stored record: code in 11..4, send flag in 3, event in 2..0
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              send;
        logic [EV_W-1:0]   ev;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

### rtl/core/kmr_if.sv
// valid/ready channel interfaces: request words, action words, register writes

// request channel
interface kmr_req_if import kmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [EV_W-1:0]   event_kind;
    logic [CODE_W-1:0] key_code;
    logic [SEL_W-1:0]  slot_sel;

    modport source (output valid, req_type, event_kind, key_code, slot_sel, input ready);
    modport sink   (input valid, req_type, event_kind, key_code, slot_sel, output ready);
endinterface

// action channel
interface kmr_act_if import kmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CODE_W-1:0] action_code;
    logic              send_report;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;

    modport source (output valid, action, action_code, send_report, wait_ms, last,
                    input ready);
    modport sink   (input valid, action, action_code, send_report, wait_ms, last,
                    output ready);
endinterface

// register write channel
interface kmr_cfg_if import kmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] send_wait_ms;

    modport source (output valid, send_wait_ms, input ready);
    modport sink   (input valid, send_wait_ms, output ready);
endinterface

### rtl/core/kmr_ram.sv
// generic single write port, single read port ram with registered read data
module kmr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 160,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/key_macro_recorder.sv
// key macro recorder top level: request sequencer, slot bookkeeping, record ram
//
// Channels: req takes one request word (record event, mark send, start, stop,
// toggle, clear, play); act gives action words; cfg writes send_wait_ms.
// cfg is always ready; the user writes it only while the block is idle, the block itself does not enforce it.
// Records of all slots sit in one ram of SLOTS*RECORDS entries with one
// write and one registered read port; a small sequencer does every step.
// Start, stop, toggle, clear and dropped events end in idle; a record event
// on an empty slot goes to append; a mark send, a fold or a merge into the
// previous record reads it and writes it back in check, and an append behind
// it goes check then append, plus a read and check of the record before when
// a modifier add is cancelled. req.ready is low while a request is in work.
// Play reads each record through the ram read port into the output register,
// then sends the closing clear word (last set): count+1 words in all.
// The action word sits in an output register: the next request is taken
// while it waits, and a stalled receiver holds play at that word.
// Reset: not recording, slot 0, all slots empty, send_wait_ms 0; the ram
// needs no clearing since only written entries are ever played.
module key_macro_recorder import kmr_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int RECORDS = RECORDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kmr_req_if.sink   req,
    kmr_act_if.source act,
    kmr_cfg_if.sink   cfg
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(RECORDS + 1);
    localparam int DEPTH  = SLOTS * RECORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_APP  = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_PLD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic              recording_reg, recording_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [IDX_W-1:0]  cnt_reg [SLOTS];
    logic [IDX_W-1:0]  cnt_next [SLOTS];
    logic [EV_W-1:0]   ev_reg, ev_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              mark_reg, mark_next;
    logic              second_reg, second_next;
    logic [IDX_W-1:0]  play_i_reg, play_i_next;
    logic [IDX_W-1:0]  play_n_reg, play_n_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;

    logic              ov_reg, ov_next;
    logic [ACT_W-1:0]  o_action_reg, o_action_next;
    logic [CODE_W-1:0] o_code_reg, o_code_next;
    logic              o_send_reg, o_send_next;
    logic              o_last_reg, o_last_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    rec_t              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_rdata_raw;
    rec_t              prev;

    logic              req_fire;
    logic              out_free;
    logic [SLOT_W-1:0] sel_slot;
    logic              can_rec;
    logic              null_ev;
    logic [IDX_W-1:0]  wi_dec;
    logic [IDX_W-1:0]  cnt_cur;

    // ram address of entry i of slot s
    function automatic logic [ADDR_W-1:0] rec_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [IDX_W-1:0] i);
        rec_addr = ADDR_W'(32'(s) * RECORDS + 32'(i));
    endfunction

    // record store
    kmr_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign prev = rec_t'(ram_rdata_raw);

    // handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !ov_reg || act.ready;
    assign cfg.ready = 1'b1;

    // request decode helpers
    assign sel_slot = (32'(req.slot_sel) < SLOTS) ? SLOT_W'(req.slot_sel) : cur_slot_reg;
    assign can_rec  = recording_reg && (wi_reg < IDX_W'(RECORDS));
    assign null_ev  = (req.key_code == '0) &&
                      (req.event_kind inside {EV_ADD_KEY, EV_DEL_KEY, EV_ADD_MOD, EV_DEL_MOD});
    assign wi_dec   = wi_reg - 1'b1;
    assign cnt_cur  = cnt_reg[cur_slot_reg];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        recording_next = recording_reg;
        cur_slot_next  = cur_slot_reg;
        wi_next        = wi_reg;
        cnt_next       = cnt_reg;
        ev_next        = ev_reg;
        code_next      = code_reg;
        mark_next      = mark_reg;
        second_next    = second_reg;
        play_i_next    = play_i_reg;
        play_n_next    = play_n_reg;
        wait_next      = cfg.valid ? cfg.send_wait_ms : wait_reg;
        ov_next        = ov_reg && !act.ready;
        o_action_next  = o_action_reg;
        o_code_next    = o_code_reg;
        o_send_next    = o_send_reg;
        o_last_next    = o_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = rec_addr(cur_slot_reg, wi_dec);
        ram_wdata      = prev;
        ram_re         = 1'b0;
        ram_raddr      = rec_addr(cur_slot_reg, wi_dec);

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.req_type)
                        REQ_RECORD:
                        begin
                            if (can_rec && !null_ev)
                            begin
                                ev_next     = req.event_kind;
                                code_next   = req.key_code;
                                mark_next   = 1'b0;
                                second_next = 1'b0;
                                if (wi_reg != '0)
                                begin
                                    ram_re     = 1'b1;
                                    state_next = S_CHK;
                                end
                                else
                                begin
                                    state_next = S_APP;
                                end
                            end
                        end
                        REQ_MARK:
                        begin
                            if (can_rec && (wi_reg != '0))
                            begin
                                mark_next  = 1'b1;
                                ram_re     = 1'b1;
                                state_next = S_CHK;
                            end
                        end
                        REQ_START:
                        begin
                            cur_slot_next      = sel_slot;
                            recording_next     = 1'b1;
                            wi_next            = '0;
                            cnt_next[sel_slot] = '0;
                        end
                        REQ_STOP:
                        begin
                            cur_slot_next  = sel_slot;
                            recording_next = 1'b0;
                            wi_next        = '0;
                        end
                        REQ_TOGGLE:
                        begin
                            cur_slot_next  = sel_slot;
                            recording_next = !recording_reg;
                            wi_next        = '0;
                            if (!recording_reg)
                            begin
                                cnt_next[sel_slot] = '0;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cur_slot_next      = sel_slot;
                            recording_next     = 1'b0;
                            wi_next            = '0;
                            cnt_next[sel_slot] = '0;
                        end
                        REQ_PLAY:
                        begin
                            cur_slot_next  = sel_slot;
                            recording_next = 1'b0;
                            wi_next        = '0;
                            play_i_next    = '0;
                            play_n_next    = cnt_reg[sel_slot];
                            state_next     = (cnt_reg[sel_slot] == '0) ? S_FIN : S_PRD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // previous record is in the read register
            S_CHK:
            begin
                if (mark_reg)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = prev;
                    ram_wdata.send = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!second_reg && (ev_reg == EV_DEL_KEY) && prev.send &&
                         (prev.ev == EV_ADD_KEY) && (prev.code == code_reg))
                begin
                    // a press marked send, then its release, folds into one type record
                    ram_we     = 1'b1;
                    ram_wdata  = '{code: code_reg, send: 1'b1, ev: EV_TYPE};
                    state_next = S_IDLE;
                end
                else if (!second_reg && (ev_reg == EV_DEL_MOD) &&
                         (prev.ev == EV_ADD_MOD) && (prev.code == code_reg))
                begin
                    // drop the modifier add, the delete still goes on
                    wi_next = wi_dec;
                    if (cnt_cur != '0)
                    begin
                        cnt_next[cur_slot_reg] = cnt_cur - 1'b1;
                    end
                    state_next = (wi_dec != '0) ? S_RD2 : S_APP;
                end
                else if (((ev_reg == EV_ADD_MOD) && (prev.ev == EV_ADD_MOD)) ||
                         ((ev_reg == EV_DEL_MOD) && (prev.ev == EV_DEL_MOD)))
                begin
                    // merge modifier masks
                    ram_we         = 1'b1;
                    ram_wdata      = prev;
                    ram_wdata.code = prev.code | code_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_APP;
                end
            end

            // fetch the record before the removed one
            S_RD2:
            begin
                ram_re      = 1'b1;
                second_next = 1'b1;
                state_next  = S_CHK;
            end

            // append a fresh record
            S_APP:
            begin
                ram_we    = 1'b1;
                ram_waddr = rec_addr(cur_slot_reg, wi_reg);
                ram_wdata = '{code: code_reg, send: 1'b0, ev: ev_reg};
                wi_next   = wi_reg + 1'b1;
                if (cnt_cur < IDX_W'(RECORDS))
                begin
                    cnt_next[cur_slot_reg] = cnt_cur + 1'b1;
                end
                state_next = S_IDLE;
            end

            // play: read the next record
            S_PRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rec_addr(cur_slot_reg, play_i_reg);
                state_next = S_PLD;
            end

            // play: hand the record to the output register
            S_PLD:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_action_next = {1'b0, prev.ev};
                    o_code_next   = prev.code;
                    o_send_next   = prev.send;
                    o_last_next   = 1'b0;
                    play_i_next   = play_i_reg + 1'b1;
                    state_next    = ((play_i_reg + 1'b1) == play_n_reg) ? S_FIN : S_PRD;
                end
            end

            // play: closing clear word
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_action_next = ACT_FINAL;
                    o_code_next   = '0;
                    o_send_next   = 1'b0;
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            recording_reg <= 1'b0;
            cur_slot_reg  <= '0;
            wi_reg        <= '0;
            cnt_reg       <= '{default: '0};
            mark_reg      <= 1'b0;
            second_reg    <= 1'b0;
            play_i_reg    <= '0;
            play_n_reg    <= '0;
            wait_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            recording_reg <= recording_next;
            cur_slot_reg  <= cur_slot_next;
            wi_reg        <= wi_next;
            cnt_reg       <= cnt_next;
            mark_reg      <= mark_next;
            second_reg    <= second_next;
            play_i_reg    <= play_i_next;
            play_n_reg    <= play_n_next;
            wait_reg      <= wait_next;
            ov_reg        <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ev_reg       <= ev_next;
        code_reg     <= code_next;
        o_action_reg <= o_action_next;
        o_code_reg   <= o_code_next;
        o_send_reg   <= o_send_next;
        o_last_reg   <= o_last_next;
    end

    // action word out
    assign act.valid       = ov_reg;
    assign act.action      = o_action_reg;
    assign act.action_code = o_code_reg;
    assign act.send_report = o_send_reg;
    assign act.wait_ms     = o_send_reg ? wait_reg : '0;
    assign act.last        = o_last_reg;

`ifndef NO_ASSERTIONS
    // write index never passes the slot size
    a_wi_range: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= IDX_W'(RECORDS))
        else $error("write index beyond slot size");

    // while recording, the slot count follows the write index
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (recording_reg && (state_reg == S_IDLE)) |-> (cnt_reg[cur_slot_reg] == wi_reg))
        else $error("slot count out of step with write index");

    // the last word of a play run is the closing clear
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        (act.valid && act.last) |-> ((act.action == ACT_FINAL) && !act.send_report &&
                                     (act.action_code == '0)))
        else $error("last word is not the closing clear");

    // no request is taken while a play run is still being walked
    a_play_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_PLAY)) |=> !req.ready)
        else $error("request taken during play");
`endif

endmodule
